/* sv/npvf_pkg.sv */
// ----------------------------------------------------------------------------
// npvf_pkg
// Shared types and constants for the nearest peak / valley finder.
// ----------------------------------------------------------------------------
package npvf_pkg;

    localparam int BUF_DEPTH    = 1024;
    localparam int ADDR_W       = 10;
    localparam int IDX_W        = ADDR_W + 1;
    localparam int LEN_W        = 11;
    localparam int SAMPLE_W     = 8;
    localparam int WINDOW_DEF   = 375;
    localparam int MAX_EXT_DEF  = 2;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;
    localparam logic DIR_FWD     = 1'b0;
    localparam logic DIR_BWD     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FETCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_HIT,
        CLS_SCAN_FWD,
        CLS_SCAN_BWD
    } t_cls;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
        logic [ADDR_W-1:0]          index;
        logic [IDX_W-1:0]           span;
    } t_best;

endpackage

/* sv/nearest_peak_valley_finder_top.sv */
// ----------------------------------------------------------------------------
// nearest_peak_valley_finder_top
// Stores waveform samples and finds the nearest dominant peak and valley
// around a query centre.
// ----------------------------------------------------------------------------
// A store word is written straight to the sample RAM. A query walks forward,
// then backward, from the centre through the sample RAM: it primes a
// three-sample window, then steps through each sample (compare, read, shift),
// reads and compares each sample of any plateau scan, and then delivers the
// result. Each walk covers up to WINDOW samples and stops early when both
// counts fill or it meets an edge. Input stalls for the whole query.
// ----------------------------------------------------------------------------
module nearest_peak_valley_finder_top
    import npvf_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int MAX_EXTREMA = MAX_EXT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic [ADDR_W-1:0]          i_address,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [LEN_W-1:0]           i_valid_length,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic signed [SAMPLE_W-1:0] o_systolic_value,
    output logic [ADDR_W-1:0]          o_systolic_index,
    output logic signed [SAMPLE_W-1:0] o_diastolic_value,
    output logic [ADDR_W-1:0]          o_diastolic_index
);

    localparam int SW = $clog2(WINDOW + 1);
    localparam int CW = $clog2(MAX_EXTREMA + 1);

    t_state r_state, n_state;
    logic                       r_dir, n_dir;
    logic [ADDR_W-1:0]          r_center, n_center;
    logic [IDX_W-1:0]           r_size, n_size;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [SW-1:0]              r_steps, n_steps;
    logic [CW-1:0]              r_cp, n_cp, r_cv, n_cv;
    logic signed [SAMPLE_W-1:0] r_l, n_l, r_c, n_c, r_r, n_r;
    logic [1:0]                 r_ld, n_ld;
    logic [IDX_W-1:0]           r_scan, n_scan;
    logic                       r_sfwd, n_sfwd;
    logic                       r_kind, n_kind;
    t_best                      r_pk [2];
    t_best                      r_vl [2];
    t_best                      n_pk [2];
    t_best                      n_vl [2];
    logic                       r_out_valid, n_out_valid;
    logic                       r_status, n_status;
    logic signed [SAMPLE_W-1:0] r_sys_v, n_sys_v, r_dia_v, n_dia_v;
    logic [ADDR_W-1:0]          r_sys_i, n_sys_i, r_dia_i, n_dia_i;

    logic                       in_acc;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_s;

    logic                       in_range, more, walk_on, interior;
    logic [IDX_W-1:0]           ld_addr;
    t_cls                       cls;
    logic                       cons_hit, cons_kind;
    t_best                      cur_b;
    logic                       better, upd, cnt_inc;
    logic                       out_free;
    t_best                      pk_sel, vl_sel;

    npvf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_address),
        .i_wdata (i_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_s     = $signed(ram_rdata);
    assign in_acc   = i_valid && !o_stall;
    assign ram_we   = in_acc && (i_command == CMD_STORE);
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign in_range = (r_dir == DIR_BWD) ? !r_idx[IDX_W-1] : (r_idx < r_size);
    assign more     = (r_cp < CW'(MAX_EXTREMA)) || (r_cv < CW'(MAX_EXTREMA));
    assign walk_on  = more && (r_steps < SW'(WINDOW)) && in_range;
    assign interior = (r_idx != '0) &&
                      (({1'b0, r_idx} + (IDX_W+1)'(1)) < {1'b0, r_size});
    assign ld_addr  = r_idx + IDX_W'(r_ld) - IDX_W'(1);

    always_comb begin
        cls = CLS_NONE;
        if (interior) begin
            if ((r_c > r_l) && (r_c > r_r)) begin
                cls = CLS_HIT;
            end else if ((r_c < r_l) && (r_c < r_r)) begin
                cls = CLS_HIT;
            end else if ((r_c != r_l) && (r_c == r_r)) begin
                cls = CLS_SCAN_FWD;
            end else if ((r_c == r_l) && (r_c != r_r)) begin
                cls = CLS_SCAN_BWD;
            end
        end
    end

    // candidate update, shared by the direct test and the plateau scan
    always_comb begin
        cons_hit  = 1'b0;
        cons_kind = 1'b0;
        case (r_state)
            ST_CHECK: begin
                cons_hit  = walk_on && (cls == CLS_HIT);
                cons_kind = (r_c > r_l);
            end
            ST_SCAN_CMP: begin
                cons_hit  = (rd_s != r_c) && (r_kind ? (r_c > rd_s) : (r_c < rd_s));
                cons_kind = r_kind;
            end
            default: begin
                cons_hit  = 1'b0;
                cons_kind = 1'b0;
            end
        endcase
        cur_b   = cons_kind ? r_pk[r_dir] : r_vl[r_dir];
        better  = cons_kind ? (r_c > cur_b.value) : (r_c < cur_b.value);
        upd     = cons_hit && (!cur_b.valid || better);
        cnt_inc = cons_hit && (upd || (r_c != cur_b.value));
    end

    always_comb begin
        pk_sel = r_pk[DIR_BWD];
        if (r_pk[DIR_FWD].valid && r_pk[DIR_BWD].valid) begin
            if (r_pk[DIR_FWD].span < r_pk[DIR_BWD].span) pk_sel = r_pk[DIR_FWD];
        end else if (r_pk[DIR_FWD].valid) begin
            pk_sel = r_pk[DIR_FWD];
        end
        vl_sel = r_vl[DIR_BWD];
        if (r_vl[DIR_FWD].valid && r_vl[DIR_BWD].valid) begin
            if (r_vl[DIR_FWD].span < r_vl[DIR_BWD].span) vl_sel = r_vl[DIR_FWD];
        end else if (r_vl[DIR_FWD].valid) begin
            vl_sel = r_vl[DIR_FWD];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_command == CMD_QUERY)) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_ld == 2'd3) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!walk_on) begin
                    n_state = (r_dir == DIR_FWD) ? ST_LOAD : ST_DONE;
                end else if ((cls == CLS_SCAN_FWD) || (cls == CLS_SCAN_BWD)) begin
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_SCAN_RD: begin
                if (r_sfwd ? (r_scan < r_size) : !r_scan[IDX_W-1]) begin
                    n_state = ST_SCAN_CMP;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_SCAN_CMP: begin
                n_state = (rd_s == r_c) ? ST_SCAN_RD : ST_FETCH;
            end
            ST_FETCH: n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_CHECK;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_dir       = r_dir;
        n_center    = r_center;
        n_size      = r_size;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_cp        = r_cp;
        n_cv        = r_cv;
        n_l         = r_l;
        n_c         = r_c;
        n_r         = r_r;
        n_ld        = r_ld;
        n_scan      = r_scan;
        n_sfwd      = r_sfwd;
        n_kind      = r_kind;
        n_pk        = r_pk;
        n_vl        = r_vl;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_sys_v     = r_sys_v;
        n_sys_i     = r_sys_i;
        n_dia_v     = r_dia_v;
        n_dia_i     = r_dia_i;
        ram_raddr   = ld_addr[ADDR_W-1:0];

        if (upd) begin
            if (cons_kind) begin
                n_pk[r_dir] = '{valid: 1'b1, value: r_c, index: r_idx[ADDR_W-1:0],
                                span: IDX_W'(r_steps)};
            end else begin
                n_vl[r_dir] = '{valid: 1'b1, value: r_c, index: r_idx[ADDR_W-1:0],
                                span: IDX_W'(r_steps)};
            end
        end
        if (cnt_inc) begin
            if (cons_kind) begin
                if (r_cp < CW'(MAX_EXTREMA)) n_cp = r_cp + CW'(1);
            end else begin
                if (r_cv < CW'(MAX_EXTREMA)) n_cv = r_cv + CW'(1);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_command == CMD_QUERY)) begin
                    n_dir    = DIR_FWD;
                    n_center = i_address;
                    n_size   = (i_valid_length > LEN_W'(BUF_DEPTH)) ?
                               IDX_W'(BUF_DEPTH) : IDX_W'(i_valid_length);
                    n_idx    = IDX_W'(i_address);
                    n_steps  = '0;
                    n_cp     = '0;
                    n_cv     = '0;
                    n_ld     = '0;
                    n_pk[0]  = '0;
                    n_pk[1]  = '0;
                    n_vl[0]  = '0;
                    n_vl[1]  = '0;
                end
            end
            ST_LOAD: begin
                ram_raddr = ld_addr[ADDR_W-1:0];
                if (r_ld != 2'd0) begin
                    n_l = r_c;
                    n_c = r_r;
                    n_r = rd_s;
                end
                n_ld = r_ld + 2'd1;
            end
            ST_CHECK: begin
                if (!walk_on) begin
                    n_dir   = DIR_BWD;
                    n_idx   = IDX_W'(r_center);
                    n_steps = '0;
                    n_cp    = '0;
                    n_cv    = '0;
                    n_ld    = '0;
                end else begin
                    n_sfwd = (cls == CLS_SCAN_FWD);
                    n_kind = (cls == CLS_SCAN_FWD) ? (r_c > r_l) : (r_c > r_r);
                    n_scan = (cls == CLS_SCAN_FWD) ? r_idx + IDX_W'(2)
                                                    : r_idx - IDX_W'(2);
                end
            end
            ST_SCAN_RD: begin
                ram_raddr = r_scan[ADDR_W-1:0];
            end
            ST_SCAN_CMP: begin
                n_scan = r_sfwd ? r_scan + IDX_W'(1) : r_scan - IDX_W'(1);
            end
            ST_FETCH: begin
                if (r_dir == DIR_BWD) begin
                    ram_raddr = ADDR_W'(r_idx - IDX_W'(2));
                    n_idx     = r_idx - IDX_W'(1);
                end else begin
                    ram_raddr = ADDR_W'(r_idx + IDX_W'(2));
                    n_idx     = r_idx + IDX_W'(1);
                end
                n_steps = r_steps + SW'(1);
            end
            ST_SHIFT: begin
                if (r_dir == DIR_BWD) begin
                    n_r = r_c;
                    n_c = r_l;
                    n_l = rd_s;
                end else begin
                    n_l = r_c;
                    n_c = r_r;
                    n_r = rd_s;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (pk_sel.valid && vl_sel.valid) begin
                        n_status = STATUS_OK;
                        n_sys_v  = pk_sel.value;
                        n_sys_i  = pk_sel.index;
                        n_dia_v  = vl_sel.value;
                        n_dia_i  = vl_sel.index;
                    end else begin
                        n_status = STATUS_FAIL;
                        n_sys_v  = '0;
                        n_sys_i  = '0;
                        n_dia_v  = '0;
                        n_dia_i  = '0;
                    end
                end
            end
            default: begin
                ram_raddr = ld_addr[ADDR_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_dir       <= DIR_FWD;
            r_ld        <= '0;
            r_steps     <= '0;
            r_cp        <= '0;
            r_cv        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dir       <= n_dir;
            r_ld        <= n_ld;
            r_steps     <= n_steps;
            r_cp        <= n_cp;
            r_cv        <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_center <= n_center;
        r_size   <= n_size;
        r_idx    <= n_idx;
        r_l      <= n_l;
        r_c      <= n_c;
        r_r      <= n_r;
        r_scan   <= n_scan;
        r_sfwd   <= n_sfwd;
        r_kind   <= n_kind;
        r_pk     <= n_pk;
        r_vl     <= n_vl;
        r_status <= n_status;
        r_sys_v  <= n_sys_v;
        r_sys_i  <= n_sys_i;
        r_dia_v  <= n_dia_v;
        r_dia_i  <= n_dia_i;
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_systolic_value  = r_sys_v;
    assign o_systolic_index  = r_sys_i;
    assign o_diastolic_value = r_dia_v;
    assign o_diastolic_index = r_dia_i;

`ifndef SYNTHESIS
    a_query_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_QUERY)) |=> o_stall)
        else $error("query accepted without stalling input");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_FAIL)) |->
        (o_systolic_value == '0 && o_systolic_index == '0 &&
         o_diastolic_value == '0 && o_diastolic_index == '0))
        else $error("failed result carries nonzero fields");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cp <= CW'(MAX_EXTREMA)) && (r_cv <= CW'(MAX_EXTREMA)))
        else $error("extremum count beyond limit");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SW'(WINDOW))
        else $error("walk went beyond window");
`endif

endmodule

/* sv/npvf_ram.sv */
// ----------------------------------------------------------------------------
// npvf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
